/* hdl/bgc_pkg.sv */
// Package for the button gesture classifier.
// Holds the mode and gesture codes, the configuration type, reset values and helpers.
// No dependencies.
package bgc_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned GestW = 3;
  localparam int unsigned ClickW = 2;

  localparam logic [CntW-1:0]   CntMax       = '1;
  localparam logic [ClickW-1:0] ClickRunMax  = 2'd3;

  localparam logic [CntW-1:0] ClickMaxLenRst = 16'd25;
  localparam logic [CntW-1:0] MultiWindowRst = 16'd25;
  localparam logic [CntW-1:0] HoldLenRst     = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLICK_MAX_LEN = 2'd0,
    REG_MULTI_WINDOW  = 2'd1,
    REG_HOLD_LEN      = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_PRESS = 5'b00010,
    MODE_WAIT2 = 5'b00100,
    MODE_WAIT3 = 5'b01000,
    MODE_HELD  = 5'b10000
  } mode_e;

  typedef enum logic [GestW-1:0] {
    G_NONE    = 3'd0,
    G_CLICK   = 3'd1,
    G_DOUBLE  = 3'd2,
    G_TRIPLE  = 3'd3,
    G_HOLD    = 3'd4,
    G_RELEASE = 3'd5
  } gesture_e;

  typedef struct packed {
    logic [CntW-1:0] click_max_len;
    logic [CntW-1:0] multi_click_window;
    logic [CntW-1:0] hold_len;
  } cfg_t;

  // zero behaves as one
  function automatic logic [CntW-1:0] at_least_one(input logic [CntW-1:0] v);
    return (v == '0) ? {{(CntW-1){1'b0}}, 1'b1} : v;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + {{(CntW-1){1'b0}}, 1'b1};
  endfunction

endpackage

/* hdl/bgc_cfg.sv */
// Configuration registers of the button gesture classifier.
// Depends on bgc_pkg.
module bgc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bgc_pkg::CntW-1:0]     cfg_wdata_i,
  output bgc_pkg::cfg_t                cfg_o
);

  bgc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bgc_pkg::cfg_reg_e'(cfg_idx_i))
        bgc_pkg::REG_CLICK_MAX_LEN: cfg_d.click_max_len      = cfg_wdata_i;
        bgc_pkg::REG_MULTI_WINDOW:  cfg_d.multi_click_window = cfg_wdata_i;
        bgc_pkg::REG_HOLD_LEN:      cfg_d.hold_len           = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_max_len      <= bgc_pkg::ClickMaxLenRst;
      cfg_q.multi_click_window <= bgc_pkg::MultiWindowRst;
      cfg_q.hold_len           <= bgc_pkg::HoldLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/bgc_core.sv */
// Gesture state machine: mode, press and release counters, click count.
// Computes the gesture of one sample; state advances when step_i is high.
// Depends on bgc_pkg.
module bgc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        pressed_i,
  input  bgc_pkg::cfg_t               cfg_i,
  output logic [bgc_pkg::GestW-1:0]   gesture_o
);

  localparam logic [bgc_pkg::CntW-1:0]   One   = {{(bgc_pkg::CntW-1){1'b0}}, 1'b1};
  localparam logic [bgc_pkg::ClickW-1:0] OneCk = {{(bgc_pkg::ClickW-1){1'b0}}, 1'b1};

  bgc_pkg::mode_e                mode_q, mode_d;
  logic [bgc_pkg::CntW-1:0]      press_len_q, press_len_d;
  logic [bgc_pkg::CntW-1:0]      release_wait_q, release_wait_d;
  logic [bgc_pkg::ClickW-1:0]    clicks_q, clicks_d;
  bgc_pkg::gesture_e             gest;

  logic [bgc_pkg::CntW-1:0]      press_inc, wait_inc;
  logic [bgc_pkg::CntW-1:0]      click_lim, win_lim, hold_lim;
  logic [bgc_pkg::ClickW-1:0]    clicks_inc;

  assign press_inc  = bgc_pkg::sat_inc(press_len_q);
  assign wait_inc   = bgc_pkg::sat_inc(release_wait_q);
  assign click_lim  = bgc_pkg::at_least_one(cfg_i.click_max_len);
  assign win_lim    = bgc_pkg::at_least_one(cfg_i.multi_click_window);
  assign hold_lim   = bgc_pkg::at_least_one(cfg_i.hold_len);
  assign clicks_inc = clicks_q + OneCk;

  always_comb begin
    mode_d         = mode_q;
    press_len_d    = press_len_q;
    release_wait_d = release_wait_q;
    clicks_d       = clicks_q;
    gest           = bgc_pkg::G_NONE;
    case (mode_q)
      bgc_pkg::MODE_IDLE: begin
        if (pressed_i) begin
          mode_d         = bgc_pkg::MODE_PRESS;
          press_len_d    = One;
          release_wait_d = '0;
          clicks_d       = '0;
        end
      end
      bgc_pkg::MODE_PRESS: begin
        if (pressed_i) begin
          press_len_d = press_inc;
          if (press_inc >= hold_lim) begin
            mode_d   = bgc_pkg::MODE_HELD;
            clicks_d = '0;
            gest     = bgc_pkg::G_HOLD;
          end
        end else if (press_len_q <= click_lim) begin
          clicks_d       = clicks_inc;
          release_wait_d = '0;
          if (clicks_inc >= bgc_pkg::ClickRunMax) begin
            mode_d      = bgc_pkg::MODE_IDLE;
            press_len_d = '0;
            clicks_d    = '0;
            gest        = bgc_pkg::G_TRIPLE;
          end else if (clicks_inc == OneCk) begin
            mode_d = bgc_pkg::MODE_WAIT2;
          end else begin
            mode_d = bgc_pkg::MODE_WAIT3;
          end
        end else begin
          // long press released before hold: run dropped
          mode_d         = bgc_pkg::MODE_IDLE;
          press_len_d    = '0;
          release_wait_d = '0;
          clicks_d       = '0;
        end
      end
      bgc_pkg::MODE_WAIT2, bgc_pkg::MODE_WAIT3: begin
        if (pressed_i) begin
          mode_d      = bgc_pkg::MODE_PRESS;
          press_len_d = One;
        end else begin
          release_wait_d = wait_inc;
          if (wait_inc >= win_lim) begin
            mode_d         = bgc_pkg::MODE_IDLE;
            press_len_d    = '0;
            release_wait_d = '0;
            clicks_d       = '0;
            gest           = (mode_q == bgc_pkg::MODE_WAIT2) ? bgc_pkg::G_CLICK
                                                             : bgc_pkg::G_DOUBLE;
          end
        end
      end
      bgc_pkg::MODE_HELD: begin
        if (!pressed_i) begin
          mode_d         = bgc_pkg::MODE_IDLE;
          press_len_d    = '0;
          release_wait_d = '0;
          clicks_d       = '0;
          gest           = bgc_pkg::G_RELEASE;
        end
      end
      default: begin
        mode_d         = bgc_pkg::MODE_IDLE;
        press_len_d    = '0;
        release_wait_d = '0;
        clicks_d       = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= bgc_pkg::MODE_IDLE;
      press_len_q    <= '0;
      release_wait_q <= '0;
      clicks_q       <= '0;
    end else if (step_i) begin
      mode_q         <= mode_d;
      press_len_q    <= press_len_d;
      release_wait_q <= release_wait_d;
      clicks_q       <= clicks_d;
    end
  end

  assign gesture_o = gest;

endmodule

/* hdl/button_gesture_classifier_unit.sv */
// Button gesture classifier: one button sample in, one gesture code out.
// Depends on bgc_pkg, bgc_cfg and bgc_core.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries pressed_i, one sample per item.
//   Output channel out_valid_o / out_ready_i carries gesture_o, one code per item:
//   0 none, 1 click, 2 double, 3 triple, 4 hold, 5 release after hold.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 click max length, 1 multi-click window, 2 hold length); index 3 is ignored.
//   Write registers only while no item is in flight.
// Timing:
//   An accepted sample is held in an input register; once the result register is
//   empty or being taken, the gesture logic updates the state and loads the result
//   register. Throughput is one item per cycle while the receiver does not stall;
//   the combinational compare-and-increment state update sets that rate.
//   If the receiver stalls, the result register holds its item and the input
//   register takes one more sample; after that in_ready_o drops.
// Reset: rst_ni clears both stages, returns to idle with zeroed counters and
//   restores the registers to 25, 25 and 100.
module button_gesture_classifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        pressed_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bgc_pkg::GestW-1:0]   gesture_o,
  input  logic                        cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bgc_pkg::CntW-1:0]    cfg_wdata_i
);

  bgc_pkg::cfg_t              cfg;
  logic                       in_valid_q, in_valid_d;
  logic                       pressed_q;
  logic                       out_valid_q, out_valid_d;
  logic [bgc_pkg::GestW-1:0]  gesture_q, gesture_d;
  logic                       step;

  bgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bgc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .pressed_i (pressed_q),
    .cfg_i     (cfg),
    .gesture_o (gesture_d)
  );

  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pressed_q <= pressed_i;
    end
    if (step) begin
      gesture_q <= gesture_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

`ifndef SYNTHESIS
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a staged item");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |=> (in_valid_q && $stable(pressed_q)))
    else $error("staged sample lost during output stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !in_valid_q) |=> !out_valid_q)
    else $error("result repeated after being taken");
`endif

endmodule

/* tb/tb_button_gesture_classifier_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for button_gesture_classifier_unit: button samples in, gesture codes out.
// Uses bgc_pkg for codes and types; a built-in tracker predicts each gesture, a scoreboard compares.
module tb_button_gesture_classifier_unit;

  localparam int unsigned StallLimit = 2000;
  localparam logic [bgc_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic pressed = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [bgc_pkg::GestW-1:0] gesture;
  logic cfg_we = 1'b0;
  logic [bgc_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [bgc_pkg::CntW-1:0] cfg_wdata = '0;

  // tracker state
  bgc_pkg::cfg_t trk_cfg;
  bgc_pkg::mode_e trk_mode;
  logic [bgc_pkg::CntW-1:0] trk_press;
  logic [bgc_pkg::CntW-1:0] trk_idle;
  logic [bgc_pkg::ClickW-1:0] trk_clicks;

  logic levels_pending[$];
  bgc_pkg::gesture_e gestures_due[$];
  bgc_pkg::gesture_e want;
  int errors = 0;
  int items_in = 0;
  int results_out = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  button_gesture_classifier_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .pressed_i  (pressed),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .gesture_o  (gesture),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [bgc_pkg::CntW-1:0] min_one(input logic [bgc_pkg::CntW-1:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  function automatic logic [bgc_pkg::CntW-1:0] bump(input logic [bgc_pkg::CntW-1:0] v);
    return (v == bgc_pkg::CntMax) ? v : v + 16'd1;
  endfunction

  function automatic void clear_track();
    trk_mode = bgc_pkg::MODE_IDLE;
    trk_press = '0;
    trk_idle = '0;
    trk_clicks = '0;
  endfunction

  function automatic bgc_pkg::gesture_e classify_sample(input logic lvl);
    bgc_pkg::gesture_e g;
    g = bgc_pkg::G_NONE;
    case (trk_mode)
      bgc_pkg::MODE_IDLE: begin
        if (lvl) begin
          trk_mode = bgc_pkg::MODE_PRESS;
          trk_press = 16'd1;
          trk_idle = '0;
          trk_clicks = '0;
        end
      end
      bgc_pkg::MODE_PRESS: begin
        if (lvl) begin
          trk_press = bump(trk_press);
          if (trk_press >= min_one(trk_cfg.hold_len)) begin
            trk_mode = bgc_pkg::MODE_HELD;
            trk_clicks = '0;
            g = bgc_pkg::G_HOLD;
          end
        end else if (trk_press <= min_one(trk_cfg.click_max_len)) begin
          trk_clicks = trk_clicks + 2'd1;
          trk_idle = '0;
          if (trk_clicks >= bgc_pkg::ClickRunMax) begin
            clear_track();
            g = bgc_pkg::G_TRIPLE;
          end else begin
            trk_mode = (trk_clicks == 2'd1) ? bgc_pkg::MODE_WAIT2 : bgc_pkg::MODE_WAIT3;
          end
        end else begin
          // long press released before hold: run dropped
          clear_track();
        end
      end
      bgc_pkg::MODE_WAIT2, bgc_pkg::MODE_WAIT3: begin
        if (lvl) begin
          trk_mode = bgc_pkg::MODE_PRESS;
          trk_press = 16'd1;
        end else begin
          trk_idle = bump(trk_idle);
          if (trk_idle >= min_one(trk_cfg.multi_click_window)) begin
            g = (trk_mode == bgc_pkg::MODE_WAIT2) ? bgc_pkg::G_CLICK : bgc_pkg::G_DOUBLE;
            clear_track();
          end
        end
      end
      bgc_pkg::MODE_HELD: begin
        if (!lvl) begin
          clear_track();
          g = bgc_pkg::G_RELEASE;
        end
      end
      default: clear_track();
    endcase
    return g;
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_error(input string what, input int exp_v, input int got_v);
    if (errors < 10) $display("%s: expected %0d got %0d", what, exp_v, got_v);
    errors++;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      pressed <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        gestures_due.push_back(classify_sample(pressed));
        items_in <= items_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (levels_pending.size() != 0) begin
          in_valid <= 1'b1;
          pressed <= levels_pending.pop_front();
          gap_left <= pick_gap((items_in / 150) % 4 == 2);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      results_out <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_out <= results_out + 1;
        if (gestures_due.size() == 0) begin
          flag_error("unexpected gesture", -1, int'(gesture));
        end else begin
          want = gestures_due.pop_front();
          if (gesture !== want) flag_error("gesture mismatch", int'(want), int'(gesture));
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (results_out >= 300 && !hold_done) begin
        // long back-pressure so the input side fills and stalls
        out_ready <= 1'b0;
        hold_left <= 400;
        hold_done <= 1'b1;
      end else if ((results_out / 170) % 4 == 1) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(10, 40);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (levels_pending.size() != 0 || in_valid || gestures_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bgc_pkg::CfgIdxW-1:0] idx,
                           input logic [bgc_pkg::CntW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      bgc_pkg::REG_CLICK_MAX_LEN: trk_cfg.click_max_len = val;
      bgc_pkg::REG_MULTI_WINDOW:  trk_cfg.multi_click_window = val;
      bgc_pkg::REG_HOLD_LEN:      trk_cfg.hold_len = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [bgc_pkg::CntW-1:0] cm,
                          input logic [bgc_pkg::CntW-1:0] win,
                          input logic [bgc_pkg::CntW-1:0] hl);
    write_reg(bgc_pkg::REG_CLICK_MAX_LEN, cm);
    write_reg(bgc_pkg::REG_MULTI_WINDOW, win);
    write_reg(bgc_pkg::REG_HOLD_LEN, hl);
  endtask

  task automatic push_run(input logic lvl, input int n);
    for (int k = 0; k < n; k++) levels_pending.push_back(lvl);
  endtask

  // mostly well-formed click runs, holds and long presses; some noise
  task automatic gen_gestures(input int n);
    int cl, w, h, base, kind, len, runs;
    cl = int'(min_one(trk_cfg.click_max_len));
    w = int'(min_one(trk_cfg.multi_click_window));
    h = int'(min_one(trk_cfg.hold_len));
    base = levels_pending.size();
    while (levels_pending.size() - base < n) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        runs = $urandom_range(1, 3);
        for (int k = 0; k < runs; k++) begin
          push_run(1'b1, $urandom_range(1, (cl < 6) ? cl : 6));
          if (k < runs - 1)
            len = $urandom_range(1, (w > 1) ? (((w - 1) < 6) ? w - 1 : 6) : 1);
          else
            len = ((w <= 40) ? w : $urandom_range(1, 5)) + $urandom_range(0, 3);
          push_run(1'b0, len);
        end
      end else if (kind < 15) begin
        push_run(1'b1, (h <= 60) ? h + $urandom_range(0, 4) : $urandom_range(1, 30));
        push_run(1'b0, $urandom_range(1, 4));
      end else if (kind < 17) begin
        push_run(1'b1, (cl < 60) ? cl + 1 + $urandom_range(0, 3) : $urandom_range(1, 20));
        push_run(1'b0, $urandom_range(1, 3));
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) levels_pending.push_back(1'($urandom_range(0, 1)));
      end
    end
  endtask

  function automatic logic [bgc_pkg::CntW-1:0] rand_reg();
    if ($urandom_range(0, 7) == 0) return bgc_pkg::CntW'($urandom_range(0, 65535));
    return bgc_pkg::CntW'($urandom_range(0, 12));
  endfunction

  initial begin
    trk_cfg.click_max_len = bgc_pkg::ClickMaxLenRst;
    trk_cfg.multi_click_window = bgc_pkg::MultiWindowRst;
    trk_cfg.hold_len = bgc_pkg::HoldLenRst;
    clear_track();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short limits, then all-zero registers and an ignored index
    set_regs(16'd2, 16'd2, 16'd4);
    @(negedge clk_i);
    push_run(1'b1, 1); push_run(1'b0, 3);
    push_run(1'b1, 1); push_run(1'b0, 1); push_run(1'b1, 2); push_run(1'b0, 3);
    push_run(1'b1, 1); push_run(1'b0, 1); push_run(1'b1, 1); push_run(1'b0, 1);
    push_run(1'b1, 1); push_run(1'b0, 1);
    push_run(1'b1, 5); push_run(1'b0, 1);
    push_run(1'b1, 3); push_run(1'b0, 1);
    wait_idle();
    set_regs(16'd0, 16'd0, 16'd0);
    write_reg(RegUnused, 16'd9);
    @(negedge clk_i);
    push_run(1'b1, 2); push_run(1'b0, 1);
    push_run(1'b1, 1); push_run(1'b0, 2);
    wait_idle();

    set_regs(bgc_pkg::ClickMaxLenRst, bgc_pkg::MultiWindowRst, bgc_pkg::HoldLenRst);
    @(negedge clk_i);
    gen_gestures(250);
    wait_idle();
    set_regs(16'hFFFF, 16'd3, 16'hFFFF);
    @(negedge clk_i);
    gen_gestures(150);
    wait_idle();
    set_regs(16'd3, 16'hFFFF, 16'd10);
    @(negedge clk_i);
    gen_gestures(150);
    wait_idle();
    set_regs(16'd0, 16'd0, 16'd0);
    @(negedge clk_i);
    gen_gestures(150);
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      set_regs(rand_reg(), rand_reg(), rand_reg());
      @(negedge clk_i);
      gen_gestures(120);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    errors += gestures_due.size();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
